// File: design/vic_pkg.sv
package vic_pkg;

  localparam int unsigned MODE_W = 2;
  localparam int unsigned OFS_W  = 10;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned LINE_W = 5;
  localparam int unsigned CTRL_W = 6;

  localparam int unsigned NUM_SOURCES_DEF = 32;
  localparam int unsigned NUM_SLOTS_DEF   = 16;

  localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LINE  = 2'd2;

  // word offsets
  localparam logic [OFS_W-1:0] OFS_IRQ_STATUS = 10'h000;
  localparam logic [OFS_W-1:0] OFS_FIQ_STATUS = 10'h001;
  localparam logic [OFS_W-1:0] OFS_RAW_STATUS = 10'h002;
  localparam logic [OFS_W-1:0] OFS_SELECT     = 10'h003;
  localparam logic [OFS_W-1:0] OFS_ENABLE     = 10'h004;
  localparam logic [OFS_W-1:0] OFS_ENABLE_CLR = 10'h005;
  localparam logic [OFS_W-1:0] OFS_SOFT       = 10'h006;
  localparam logic [OFS_W-1:0] OFS_SOFT_CLR   = 10'h007;
  localparam logic [OFS_W-1:0] OFS_CUR_VECTOR = 10'h00C;
  localparam logic [OFS_W-1:0] OFS_DEF_VECTOR = 10'h00D;
  localparam logic [OFS_W-1:0] OFS_VADDR_BASE = 10'h040;
  localparam logic [OFS_W-1:0] OFS_VCTRL_BASE = 10'h080;

  localparam int unsigned CTRL_EN_BIT = 5;

endpackage

// File: design/vic_if.sv
interface vic_req_if;
  logic                          valid;
  logic                          ready;
  logic [vic_pkg::MODE_W-1:0]    mode;
  logic [vic_pkg::OFS_W-1:0]     word_offset;
  logic [vic_pkg::DATA_W-1:0]    write_data;
  logic [vic_pkg::LINE_W-1:0]    line_index;
  logic                          line_level;

  modport source (output valid, mode, word_offset, write_data, line_index, line_level,
                  input ready);
  modport sink   (input valid, mode, word_offset, write_data, line_index, line_level,
                  output ready);
endinterface

interface vic_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [vic_pkg::DATA_W-1:0] read_data;
  logic                       irq_request;
  logic                       fiq_request;

  modport source (output valid, read_data, irq_request, fiq_request, input ready);
  modport sink   (input valid, read_data, irq_request, fiq_request, output ready);
endinterface

// File: design/vectored_interrupt_controller_core.sv
// Vectored interrupt controller: each request (bus read, bus write or line level change)
// is taken into an input register; once the result register is free, its register update,
// the lowest-slot-first vector priority search and the irq/fiq summary are done in one
// pass and captured in the result register, and one request per cycle is sustained as
// long as results are taken.
module vectored_interrupt_controller_core #(
  parameter int unsigned NUM_SOURCES = vic_pkg::NUM_SOURCES_DEF,
  parameter int unsigned NUM_SLOTS   = vic_pkg::NUM_SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  vic_req_if.sink          req,
  vic_rsp_if.source        rsp
);

  localparam int unsigned SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned DW     = vic_pkg::DATA_W;
  localparam int unsigned CW     = vic_pkg::CTRL_W;
  localparam int unsigned LW     = vic_pkg::LINE_W;

  typedef struct packed {
    logic [vic_pkg::MODE_W-1:0] mode;
    logic [vic_pkg::OFS_W-1:0]  word_offset;
    logic [DW-1:0]              write_data;
    logic [LW-1:0]              line_index;
    logic                       line_level;
  } req_t;

  // input stage
  logic s1_valid;
  req_t s1;
  logic adv;

  // state
  logic [NUM_SOURCES-1:0] line_levels, soft_pending, enable_mask, fiq_select;
  logic [DW-1:0]          current_vector, default_vector;
  logic [DW-1:0]          vaddr [NUM_SLOTS];
  logic [CW-1:0]          vctrl [NUM_SLOTS];
  logic [LW-1:0]          active_source;
  logic                   vector_active;

  logic [NUM_SOURCES-1:0] line_levels_next, soft_pending_next;
  logic [NUM_SOURCES-1:0] enable_mask_next, fiq_select_next;
  logic [DW-1:0]          current_vector_next, default_vector_next;
  logic [DW-1:0]          vaddr_next [NUM_SLOTS];
  logic [CW-1:0]          vctrl_next [NUM_SLOTS];
  logic [LW-1:0]          active_source_next;
  logic                   vector_active_next;

  logic                   is_rd, is_wr, is_line;
  logic                   vaddr_hit, vctrl_hit;
  logic [SLOT_W-1:0]      slot_idx;
  logic [NUM_SOURCES-1:0] wsrc, line_bit, eoi_bit;
  logic [NUM_SOURCES-1:0] raw_next, irqs_next, fiqs_next, raw_cur;
  logic [DW-1:0]          irq32;
  logic [NUM_SLOTS-1:0]   hit, win;
  logic                   any_hit;
  logic [DW-1:0]          win_addr;
  logic [LW-1:0]          win_src;
  logic [DW-1:0]          rd_data;

  // output register
  logic          rsp_valid;
  logic [DW-1:0] rsp_data;
  logic          rsp_irq, rsp_fiq;

  assign adv       = s1_valid && (!rsp_valid || rsp.ready);
  assign req.ready = !s1_valid || adv;

  assign rsp.valid       = rsp_valid;
  assign rsp.read_data   = rsp_data;
  assign rsp.irq_request = rsp_irq;
  assign rsp.fiq_request = rsp_fiq;

  assign is_rd   = (s1.mode == vic_pkg::MODE_READ);
  assign is_wr   = (s1.mode == vic_pkg::MODE_WRITE);
  assign is_line = (s1.mode == vic_pkg::MODE_LINE);

  assign slot_idx  = s1.word_offset[SLOT_W-1:0];
  assign vaddr_hit = (s1.word_offset[9:6] == vic_pkg::OFS_VADDR_BASE[9:6])
                     && (s1.word_offset[5:0] < 6'(NUM_SLOTS));
  assign vctrl_hit = (s1.word_offset[9:6] == vic_pkg::OFS_VCTRL_BASE[9:6])
                     && (s1.word_offset[5:0] < 6'(NUM_SLOTS));

  assign wsrc = s1.write_data[NUM_SOURCES-1:0];

  always_comb begin
    for (int i = 0; i < NUM_SOURCES; i++) begin
      line_bit[i] = (s1.line_index == LW'(i));
      eoi_bit[i]  = (active_source == LW'(i));
    end
  end

  // register update for the item in the input stage
  always_comb begin
    line_levels_next    = line_levels;
    soft_pending_next   = soft_pending;
    enable_mask_next    = enable_mask;
    fiq_select_next     = fiq_select;
    default_vector_next = default_vector;
    vector_active_next  = vector_active;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      vaddr_next[k] = vaddr[k];
      vctrl_next[k] = vctrl[k];
    end
    if (is_line) begin
      if (s1.line_level) begin
        line_levels_next = line_levels | line_bit;
      end else begin
        line_levels_next = line_levels & ~line_bit;
      end
    end
    if (is_wr) begin
      case (s1.word_offset)
        vic_pkg::OFS_SELECT:     fiq_select_next = wsrc;
        vic_pkg::OFS_ENABLE:     enable_mask_next = enable_mask | wsrc;
        vic_pkg::OFS_ENABLE_CLR: enable_mask_next = enable_mask & ~wsrc;
        vic_pkg::OFS_SOFT:       soft_pending_next = soft_pending | wsrc;
        vic_pkg::OFS_SOFT_CLR:   soft_pending_next = soft_pending & ~wsrc;
        vic_pkg::OFS_CUR_VECTOR: begin
          // end of interrupt
          if (vector_active) begin
            enable_mask_next   = enable_mask & ~eoi_bit;
            vector_active_next = 1'b0;
          end
        end
        vic_pkg::OFS_DEF_VECTOR: default_vector_next = s1.write_data;
        default: begin
          if (vaddr_hit) begin
            vaddr_next[slot_idx] = s1.write_data;
          end else if (vctrl_hit) begin
            vctrl_next[slot_idx] = s1.write_data[CW-1:0];
          end
        end
      endcase
    end
  end

  assign raw_next  = soft_pending_next | line_levels_next;
  assign irqs_next = raw_next & enable_mask_next & ~fiq_select_next;
  assign fiqs_next = raw_next & enable_mask_next & fiq_select_next;
  assign irq32     = DW'(irqs_next);

  // lowest enabled slot with a pending irq wins
  always_comb begin
    for (int k = 0; k < NUM_SLOTS; k++) begin
      hit[k] = vctrl_next[k][vic_pkg::CTRL_EN_BIT] && irq32[vctrl_next[k][LW-1:0]];
    end
  end

  assign win     = hit & (~hit + (NUM_SLOTS)'(1));
  assign any_hit = |hit;

  always_comb begin
    win_addr = '0;
    win_src  = '0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      win_addr = win_addr | (win[k] ? vaddr_next[k] : '0);
      win_src  = win_src  | (win[k] ? vctrl_next[k][LW-1:0] : '0);
    end
  end

  always_comb begin
    current_vector_next = current_vector;
    active_source_next  = active_source;
    if (any_hit) begin
      current_vector_next = win_addr;
      active_source_next  = win_src;
    end
  end

  // read data comes from the state before the item
  assign raw_cur = soft_pending | line_levels;

  always_comb begin
    rd_data = '0;
    if (is_rd) begin
      case (s1.word_offset)
        vic_pkg::OFS_IRQ_STATUS: rd_data = DW'(raw_cur & enable_mask & ~fiq_select);
        vic_pkg::OFS_FIQ_STATUS: rd_data = DW'(raw_cur & enable_mask & fiq_select);
        vic_pkg::OFS_RAW_STATUS: rd_data = DW'(raw_cur);
        vic_pkg::OFS_SELECT:     rd_data = DW'(fiq_select);
        vic_pkg::OFS_ENABLE:     rd_data = DW'(enable_mask);
        vic_pkg::OFS_SOFT:       rd_data = DW'(soft_pending);
        vic_pkg::OFS_CUR_VECTOR: rd_data = current_vector;
        vic_pkg::OFS_DEF_VECTOR: rd_data = default_vector;
        default: begin
          if (vaddr_hit) begin
            rd_data = vaddr[slot_idx];
          end else if (vctrl_hit) begin
            rd_data = DW'(vctrl[slot_idx]);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1.mode        <= req.mode;
      s1.word_offset <= req.word_offset;
      s1.write_data  <= req.write_data;
      s1.line_index  <= req.line_index;
      s1.line_level  <= req.line_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_levels    <= '0;
      soft_pending   <= '0;
      enable_mask    <= '0;
      fiq_select     <= '0;
      current_vector <= '0;
      default_vector <= '0;
      active_source  <= '0;
      vector_active  <= 1'b0;
      for (int k = 0; k < NUM_SLOTS; k++) begin
        vaddr[k] <= '0;
        vctrl[k] <= '0;
      end
    end else if (adv) begin
      line_levels    <= line_levels_next;
      soft_pending   <= soft_pending_next;
      enable_mask    <= enable_mask_next;
      fiq_select     <= fiq_select_next;
      current_vector <= current_vector_next;
      default_vector <= default_vector_next;
      active_source  <= active_source_next;
      vector_active  <= any_hit ? 1'b1 : vector_active_next;
      for (int k = 0; k < NUM_SLOTS; k++) begin
        vaddr[k] <= vaddr_next[k];
        vctrl[k] <= vctrl_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp_data <= rd_data;
      rsp_irq  <= |irqs_next;
      rsp_fiq  <= |fiqs_next;
    end
  end

  // a stalled input only happens behind a stalled full result register
  assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> (s1_valid && rsp_valid && !rsp.ready))
    else $error("input stalled without output backpressure");

  // a vector becomes active only through a slot match
  assert property (@(posedge clk) disable iff (rst)
    ($rose(vector_active) && !$past(rst)) |-> $past(adv && any_hit))
    else $error("vector activated without a match");

  // a vector is retired only by an end-of-interrupt write
  assert property (@(posedge clk) disable iff (rst)
    ($fell(vector_active) && !$past(rst)) |->
      $past(adv && is_wr && (s1.word_offset == vic_pkg::OFS_CUR_VECTOR)))
    else $error("vector retired without end of interrupt");

  // the current vector only moves on a match, which leaves a vector active
  assert property (@(posedge clk) disable iff (rst)
    (!$stable(current_vector) && !$past(rst)) |-> vector_active)
    else $error("current vector changed without an active vector");

endmodule
